>>> hw/rtl/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg
// shared types, tags and helpers for the wave header parser
// ----------------------------------------------------------------------------
package rwhp_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int ADDR_W      = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

    localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int FMT_MIN_LEN   = 16;
    localparam int FILE_HDR_LEN  = 12;
    localparam int FMT_BITS_AT   = 14;
    localparam int HDR_TAG_END   = 3;
    localparam int HDR_LEN_END   = 7;
    localparam int CHUNK_HDR_LEN = 8;

    localparam logic [31:0] MAX31 = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        PH_FILE_HDR,
        PH_CHUNK_HDR,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        CAUSE_NONE,
        CAUSE_HEADER,
        CAUSE_OVERRUN,
        CAUSE_NOT_PCM,
        CAUSE_DATA,
        CAUSE_RATE,
        CAUSE_LAYOUT
    } t_cause;

    typedef enum logic [1:0] {
        SF_MONO8,
        SF_MONO16,
        SF_STEREO8,
        SF_STEREO16
    } t_format;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [ADDR_W-1:0] chunk_start;
        logic [31:0]       window;
        logic [31:0]       tag;
        logic [31:0]       length;
        logic [ADDR_W-1:0] payload_end;
        t_phase            phase;
        logic [15:0]       encoding;
        logic [15:0]       channels;
        logic [15:0]       sample_bits;
        logic [31:0]       rate;
        logic [31:0]       data_offset;
        logic [31:0]       data_length;
        logic              data_found;
        t_cause            error;
    } t_state;

    typedef struct packed {
        logic        parse_ok;
        t_cause      fail_cause;
        t_format     sample_format;
        logic [30:0] rate_hz;
        logic [31:0] data_offset;
        logic [30:0] data_length;
    } t_result;

    function automatic t_state state_reset();
        t_state st;
        st             = '0;
        st.chunk_start = ADDR_W'(FILE_HDR_LEN);
        st.phase       = PH_FILE_HDR;
        st.error       = CAUSE_NONE;
        return st;
    endfunction

endpackage

>>> hw/rtl/rwhp_in_if.sv
// ----------------------------------------------------------------------------
// rwhp_in_if
// byte stream channel into the wave header parser
// ----------------------------------------------------------------------------
interface rwhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/rwhp_out_if.sv
// ----------------------------------------------------------------------------
// rwhp_out_if
// result channel out of the wave header parser
// ----------------------------------------------------------------------------
interface rwhp_out_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [2:0]  fail_cause;
    logic [1:0]  sample_format;
    logic [30:0] rate_hz;
    logic [31:0] data_offset;
    logic [30:0] data_length;

    modport source (
        output valid, output parse_ok, output fail_cause, output sample_format,
        output rate_hz, output data_offset, output data_length, input ready
    );
    modport sink (
        input valid, input parse_ok, input fail_cause, input sample_format,
        input rate_hz, input data_offset, input data_length, output ready
    );
endinterface

>>> hw/rtl/rwhp_step.sv
// ----------------------------------------------------------------------------
// rwhp_step
// next parser state for one file byte, and the verdict on the last byte
// ----------------------------------------------------------------------------
module rwhp_step
    import rwhp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    function automatic t_state flag_error(t_state st, t_cause c);
        t_state r;
        r = st;
        if (r.error == CAUSE_NONE) begin
            r.error = c;
        end
        r.phase = PH_SKIP;
        return r;
    endfunction

    t_state            s;
    t_cause            cause;
    t_format           fmt;
    logic [ADDR_W-1:0] pos_x;
    logic [ADDR_W-1:0] rel_hdr;
    logic [ADDR_W-1:0] rel_pl;
    logic [ADDR_W-1:0] start;
    logic [32:0]       padded;
    logic              hdr_fail;

    always_comb begin
        s        = i_state;
        pos_x    = ADDR_W'(i_state.pos);
        rel_hdr  = pos_x - i_state.chunk_start;
        rel_pl   = pos_x - i_state.chunk_start - ADDR_W'(CHUNK_HDR_LEN);
        start    = i_state.chunk_start + ADDR_W'(CHUNK_HDR_LEN);
        hdr_fail = 1'b0;
        padded   = '0;
        if (i_state.pos >= POS_LIMIT) begin
            s = flag_error(s, CAUSE_OVERRUN);
        end else begin
            s.pos    = i_state.pos + POS_W'(1);
            s.window = {i_byte, i_state.window[31:8]};
            unique case (i_state.phase)
                PH_FILE_HDR: begin
                    if (i_state.pos == POS_W'(HDR_TAG_END) && s.window != TAG_RIFF) begin
                        s = flag_error(s, CAUSE_HEADER);
                    end else if (i_state.pos == POS_W'(FILE_HDR_LEN - 1)) begin
                        if (s.window != TAG_WAVE) begin
                            s = flag_error(s, CAUSE_HEADER);
                        end else begin
                            s.phase = PH_CHUNK_HDR;
                        end
                    end
                end
                PH_CHUNK_HDR: begin
                    if (rel_hdr == ADDR_W'(HDR_TAG_END)) begin
                        s.tag = s.window;
                    end else if (rel_hdr == ADDR_W'(HDR_LEN_END)) begin
                        s.length = s.window;
                        padded   = {1'b0, s.window} + 33'(s.window[0]);
                        if (i_state.tag == TAG_DATA) begin
                            if (start[ADDR_W-1:32] != '0) begin
                                hdr_fail = 1'b1;
                                s        = flag_error(s, CAUSE_OVERRUN);
                            end else begin
                                s.data_offset = start[31:0];
                                s.data_length = s.window;
                                s.data_found  = 1'b1;
                            end
                        end
                        if (!hdr_fail) begin
                            if (padded == '0) begin
                                s.chunk_start = start;
                            end else begin
                                s.payload_end = start + ADDR_W'(padded);
                                s.phase       = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (i_state.tag == TAG_FMT
                            && i_state.length >= 32'(FMT_MIN_LEN)
                            && rel_pl < ADDR_W'(FMT_MIN_LEN)) begin
                        case (rel_pl[3:0])
                            4'd0:  s.encoding[7:0]     = i_byte;
                            4'd1:  s.encoding[15:8]    = i_byte;
                            4'd2:  s.channels[7:0]     = i_byte;
                            4'd3:  s.channels[15:8]    = i_byte;
                            4'd4:  s.rate[7:0]         = i_byte;
                            4'd5:  s.rate[15:8]        = i_byte;
                            4'd6:  s.rate[23:16]       = i_byte;
                            4'd7:  s.rate[31:24]       = i_byte;
                            4'd14: s.sample_bits[7:0]  = i_byte;
                            4'd15: s.sample_bits[15:8] = i_byte;
                            default: ;
                        endcase
                    end
                    if (pos_x + ADDR_W'(1) == i_state.payload_end) begin
                        s.chunk_start = i_state.payload_end;
                        s.phase       = PH_CHUNK_HDR;
                    end
                end
                PH_SKIP: ;
                default: ;
            endcase
        end

        fmt   = SF_MONO8;
        cause = CAUSE_NONE;
        if (s.error != CAUSE_NONE) begin
            cause = s.error;
        end else if (s.phase == PH_FILE_HDR) begin
            cause = CAUSE_HEADER;
        end else if (s.phase == PH_PAYLOAD) begin
            cause = CAUSE_OVERRUN;
        end else if (s.encoding != 16'd1) begin
            cause = CAUSE_NOT_PCM;
        end else if (!s.data_found || s.data_length == '0 || s.data_length > MAX31) begin
            cause = CAUSE_DATA;
        end else if (s.rate == '0 || s.rate > MAX31) begin
            cause = CAUSE_RATE;
        end else if (s.channels == 16'd1 && s.sample_bits == 16'd8) begin
            fmt = SF_MONO8;
        end else if (s.channels == 16'd1 && s.sample_bits == 16'd16) begin
            fmt = SF_MONO16;
        end else if (s.channels == 16'd2 && s.sample_bits == 16'd8) begin
            fmt = SF_STEREO8;
        end else if (s.channels == 16'd2 && s.sample_bits == 16'd16) begin
            fmt = SF_STEREO16;
        end else begin
            cause = CAUSE_LAYOUT;
        end

        o_result.parse_ok   = (cause == CAUSE_NONE);
        o_result.fail_cause = cause;
        if (cause == CAUSE_NONE) begin
            o_result.sample_format = fmt;
            o_result.rate_hz       = s.rate[30:0];
            o_result.data_offset   = s.data_offset;
            o_result.data_length   = s.data_length[30:0];
        end else begin
            o_result.sample_format = SF_MONO8;
            o_result.rate_hz       = '0;
            o_result.data_offset   = '0;
            o_result.data_length   = '0;
        end

        o_state = i_last ? state_reset() : s;
    end

endmodule

>>> hw/rtl/riff_wave_header_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// streaming RIFF/WAVE PCM header parser, one file byte per transaction
// ----------------------------------------------------------------------------
// i_in carries the file one byte per transaction, last_byte set on the final
// byte. o_out carries one result transaction per file, produced by the byte
// that has last_byte set; no other byte produces a result.
// a byte is first held in an input register, then the parser state and, on
// the last byte, the result register are written: the result is valid the
// cycle after the last byte leaves the input register. the state update is a
// single pass of compares and adds, so a byte is taken every cycle,
// including the first byte of the next file while the previous result still
// waits on o_out, unless a last byte is held back as below.
// when o_out is stalled and a last byte reaches the input register, that
// byte waits there and i_in.ready drops until the result is taken.
// reset (synchronous, active low) empties both registers and puts the parser
// at the start of a file; after each result the parser starts afresh too.
// ----------------------------------------------------------------------------
module riff_wave_header_parser
    import rwhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    rwhp_in_if.sink           i_in,
    rwhp_out_if.source        o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       out_free;
    logic       advance;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || advance;

    rwhp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= state_reset();
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && r_in_last) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.parse_ok      = r_out.parse_ok;
    assign o_out.fail_cause    = r_out.fail_cause;
    assign o_out.sample_format = r_out.sample_format;
    assign o_out.rate_hz       = r_out.rate_hz;
    assign o_out.data_offset   = r_out.data_offset;
    assign o_out.data_length   = r_out.data_length;

    a_fail_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.parse_ok |->
            o_out.rate_hz == '0 && o_out.data_offset == '0 && o_out.data_length == '0)
        else $error("failed result carries nonzero fields");

    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_PAYLOAD |-> r_state.payload_end > r_state.chunk_start)
        else $error("payload end not past chunk start");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= POS_LIMIT)
        else $error("byte position ran past limit");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out.valid && !r_in_valid)
        else $error("registers not empty after reset");

endmodule

>>> tb/sv/tb_riff_wave_header_parser.sv
// ----------------------------------------------------------------------------
// tb_riff_wave_header_parser
// streams whole wave files into the parser one byte per transaction and
// checks each file report against a byte-level model of the header walk;
// directed files cover the PCM formats, header, chunk and final checks,
// then random files (mostly well formed, some truncated, corrupted or noise)
// run with random gaps on the byte side and random stalls on the report side
// ----------------------------------------------------------------------------
module tb_riff_wave_header_parser
    import rwhp_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned ITEM_TARGET = 1550;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rwhp_in_if  in_ch ();
    rwhp_out_if out_ch ();

    riff_wave_header_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // header walk model
    logic [63:0] byte_pos;
    logic [63:0] chunk_base;
    logic [31:0] window;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_len;
    logic [63:0] body_end;
    t_phase      scan_phase;
    logic [15:0] enc_code;
    logic [15:0] chan_count;
    logic [15:0] bits_per;
    logic [31:0] rate_code;
    logic [31:0] pay_off;
    logic [31:0] pay_len;
    logic        have_data;
    t_cause      first_fault;

    t_result     reports_due[$];
    logic [7:0]  wave_image[$];

    int unsigned fail_count      = 0;
    int unsigned reports_checked = 0;
    int unsigned bytes_accepted  = 0;
    int unsigned cycle_count     = 0;
    int unsigned rx_wait         = 0;
    bit          tx_quiet        = 1'b0;
    bit          rx_quiet        = 1'b0;

    function automatic void clear_wave_scan();
        byte_pos    = '0;
        chunk_base  = 64'(FILE_HDR_LEN);
        window      = '0;
        chunk_tag   = '0;
        chunk_len   = '0;
        body_end    = '0;
        scan_phase  = PH_FILE_HDR;
        enc_code    = '0;
        chan_count  = '0;
        bits_per    = '0;
        rate_code   = '0;
        pay_off     = '0;
        pay_len     = '0;
        have_data   = 1'b0;
        first_fault = CAUSE_NONE;
    endfunction

    function automatic void note_fault(t_cause c);
        if (first_fault == CAUSE_NONE) first_fault = c;
        scan_phase = PH_SKIP;
    endfunction

    function automatic void parse_wave_byte(logic [7:0] b8, logic last);
        logic [63:0] p;
        logic [63:0] rel;
        logic [63:0] start;
        logic [63:0] padded;
        t_cause      cause;
        t_format     fmt;
        t_result     r;
        p     = byte_pos;
        cause = CAUSE_NONE;
        fmt   = SF_MONO8;
        if (p >= (64'd1 << OFFSET_BITS)) begin
            note_fault(CAUSE_OVERRUN);
        end else begin
            byte_pos = p + 1;
            window   = {b8, window[31:8]};
            case (scan_phase)
                PH_FILE_HDR: begin
                    if (p == HDR_TAG_END && window != TAG_RIFF) begin
                        note_fault(CAUSE_HEADER);
                    end else if (p == FILE_HDR_LEN - 1) begin
                        if (window != TAG_WAVE) note_fault(CAUSE_HEADER);
                        else scan_phase = PH_CHUNK_HDR;
                    end
                end
                PH_CHUNK_HDR: begin
                    rel = p - chunk_base;
                    if (rel == HDR_TAG_END) begin
                        chunk_tag = window;
                    end else if (rel == HDR_LEN_END) begin
                        chunk_len = window;
                        start     = chunk_base + CHUNK_HDR_LEN;
                        padded    = 64'(chunk_len) + 64'(chunk_len[0]);
                        if (chunk_tag == TAG_DATA && start > 64'hFFFF_FFFF) begin
                            note_fault(CAUSE_OVERRUN);
                        end else begin
                            if (chunk_tag == TAG_DATA) begin
                                pay_off   = start[31:0];
                                pay_len   = chunk_len;
                                have_data = 1'b1;
                            end
                            if (padded == 0) begin
                                chunk_base = start;
                            end else begin
                                body_end   = start + padded;
                                scan_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    rel = p - chunk_base - CHUNK_HDR_LEN;
                    if (chunk_tag == TAG_FMT && chunk_len >= FMT_MIN_LEN
                            && rel < FMT_MIN_LEN) begin
                        if (rel < 2) enc_code[8*rel[0] +: 8] = b8;
                        else if (rel < 4) chan_count[8*rel[0] +: 8] = b8;
                        else if (rel < 8) rate_code[8*rel[1:0] +: 8] = b8;
                        else if (rel >= FMT_BITS_AT) bits_per[8*rel[0] +: 8] = b8;
                    end
                    if (p + 1 == body_end) begin
                        chunk_base = body_end;
                        scan_phase = PH_CHUNK_HDR;
                    end
                end
                default: ;
            endcase
        end
        if (last) begin
            if (first_fault != CAUSE_NONE) cause = first_fault;
            else if (scan_phase == PH_FILE_HDR) cause = CAUSE_HEADER;
            else if (scan_phase == PH_PAYLOAD) cause = CAUSE_OVERRUN;
            else if (enc_code != 1) cause = CAUSE_NOT_PCM;
            else if (!have_data || pay_len == 0 || pay_len > MAX31) cause = CAUSE_DATA;
            else if (rate_code == 0 || rate_code > MAX31) cause = CAUSE_RATE;
            else if (chan_count == 1 && bits_per == 8) fmt = SF_MONO8;
            else if (chan_count == 1 && bits_per == 16) fmt = SF_MONO16;
            else if (chan_count == 2 && bits_per == 8) fmt = SF_STEREO8;
            else if (chan_count == 2 && bits_per == 16) fmt = SF_STEREO16;
            else cause = CAUSE_LAYOUT;
            r            = '0;
            r.parse_ok   = (cause == CAUSE_NONE);
            r.fail_cause = cause;
            if (cause == CAUSE_NONE) begin
                r.sample_format = fmt;
                r.rate_hz       = rate_code[30:0];
                r.data_offset   = pay_off;
                r.data_length   = pay_len[30:0];
            end
            reports_due.push_back(r);
            clear_wave_scan();
        end
    endfunction

    // file image builders
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) wave_image.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_riff_head();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
    endfunction

    function automatic void put_chunk(logic [31:0] tag, int unsigned len);
        put_le(tag, 4);
        put_le(len, 4);
        repeat (len + (len & 1)) wave_image.push_back(8'($urandom));
    endfunction

    function automatic void put_fmt(logic [15:0] enc, logic [15:0] ch, logic [31:0] rate,
                                    logic [15:0] bits, int unsigned extra);
        int unsigned len;
        len = FMT_MIN_LEN + extra;
        put_le(TAG_FMT, 4);
        put_le(len, 4);
        put_le(32'(enc), 2);
        put_le(32'(ch), 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(32'(bits), 2);
        repeat (extra + (len & 1)) wave_image.push_back(8'($urandom));
    endfunction

    function automatic void put_pcm_file(logic [15:0] ch, logic [15:0] bits,
                                         logic [31:0] rate, int unsigned dlen);
        put_riff_head();
        put_fmt(16'd1, ch, rate, bits, 0);
        put_chunk(TAG_DATA, dlen);
    endfunction

    function automatic void put_random_fmt();
        logic [15:0] enc;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [31:0] rate;
        enc  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd1;
        ch   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
        bits = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                           : (($urandom_range(0, 1) == 0) ? 16'd8 : 16'd16);
        case ($urandom_range(0, 9))
            0:       rate = 32'd0;
            1:       rate = MAX31;
            2:       rate = 32'h8000_0000 | $urandom;
            3:       rate = $urandom;
            default: rate = $urandom_range(1, 192000);
        endcase
        put_fmt(enc, ch, rate, bits, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    endfunction

    function automatic void build_random_file();
        int unsigned kind;
        int unsigned spot;
        wave_image.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            if ($urandom_range(0, 1) == 0) put_le(TAG_RIFF, 4);
            repeat ($urandom_range(1, 40)) wave_image.push_back(8'($urandom));
            return;
        end
        put_riff_head();
        if ($urandom_range(0, 3) != 0) begin
            put_random_fmt();
            put_chunk(TAG_DATA, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                            : $urandom_range(1, 12));
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0:       put_random_fmt();
                1:       put_chunk(TAG_DATA, $urandom_range(0, 12));
                2:       put_chunk($urandom, $urandom_range(0, 9));
                default: put_chunk(TAG_FMT, $urandom_range(0, 15));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) wave_image.push_back(8'($urandom));
        if (kind == 1) begin
            spot = $urandom_range(1, wave_image.size() - 1);
            while (wave_image.size() > spot) void'(wave_image.pop_back());
        end else if (kind == 2) begin
            spot = $urandom_range(0, (wave_image.size() > 24) ? 23 : wave_image.size() - 1);
            wave_image[spot] = wave_image[spot] ^ (8'd1 << $urandom_range(0, 7));
        end
    endfunction

    // byte side
    task automatic send_byte(input logic [7:0] b8, input logic last);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b8;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        parse_wave_byte(b8, last);
        bytes_accepted++;
    endtask

    task automatic send_image();
        for (int i = 0; i < wave_image.size(); i++)
            send_byte(wave_image[i], i == wave_image.size() - 1);
        wave_image.delete();
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (reports_due.size() != 0);
    endtask

    // report side
    function automatic void check_report();
        t_result want;
        if (reports_due.size() == 0) begin
            $error("report with no file pending: fail_cause %0d", out_ch.fail_cause);
            fail_count++;
            return;
        end
        want = reports_due.pop_front();
        reports_checked++;
        if (out_ch.parse_ok !== want.parse_ok) begin
            $error("parse_ok: expected %0d, actual %0d", want.parse_ok, out_ch.parse_ok);
            fail_count++;
        end
        if (out_ch.fail_cause !== want.fail_cause) begin
            $error("fail_cause: expected %0d, actual %0d", want.fail_cause, out_ch.fail_cause);
            fail_count++;
        end
        if (out_ch.sample_format !== want.sample_format) begin
            $error("sample_format: expected %0d, actual %0d",
                   want.sample_format, out_ch.sample_format);
            fail_count++;
        end
        if (out_ch.rate_hz !== want.rate_hz) begin
            $error("rate_hz: expected %0d, actual %0d", want.rate_hz, out_ch.rate_hz);
            fail_count++;
        end
        if (out_ch.data_offset !== want.data_offset) begin
            $error("data_offset: expected %0d, actual %0d", want.data_offset, out_ch.data_offset);
            fail_count++;
        end
        if (out_ch.data_length !== want.data_length) begin
            $error("data_length: expected %0d, actual %0d", want.data_length, out_ch.data_length);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait = $urandom_range(0, 17);
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_report();
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
            end
            if (rx_wait != 0) begin
                if (out_ch.valid) rx_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // tests
    task automatic test_pcm_formats();
        put_pcm_file(16'd1, 16'd8, 32'd1, 1);
        send_image();
        put_pcm_file(16'd1, 16'd16, MAX31, 2);
        send_image();
        put_riff_head();
        put_fmt(16'd1, 16'd2, 32'd44100, 16'd8, 3);
        put_chunk(32'h5453_494C, 5);
        put_chunk(TAG_DATA, 3);
        send_image();
        // data ahead of fmt
        put_riff_head();
        put_chunk(TAG_DATA, 4);
        put_fmt(16'd1, 16'd2, 32'd8000, 16'd16, 0);
        send_image();
    endtask

    task automatic test_header_faults();
        wave_image.push_back(8'hFF);
        send_image();
        put_le(32'h5846_4952, 4);
        send_image();
        put_pcm_file(16'd1, 16'd8, 32'd8000, 2);
        while (wave_image.size() > FILE_HDR_LEN - 1) void'(wave_image.pop_back());
        send_image();
        put_pcm_file(16'd1, 16'd8, 32'd8000, 2);
        wave_image[3] = 8'h58;
        send_image();
        put_pcm_file(16'd1, 16'd8, 32'd8000, 2);
        wave_image[8] = wave_image[8] ^ 8'h20;
        send_image();
        put_riff_head();
        send_image();
    endtask

    task automatic test_chunk_walk();
        // file ends inside the data payload
        put_pcm_file(16'd2, 16'd16, 32'd22050, 8);
        void'(wave_image.pop_back());
        void'(wave_image.pop_back());
        send_image();
        // file ends where the pad byte belongs
        put_pcm_file(16'd1, 16'd8, 32'd11025, 3);
        void'(wave_image.pop_back());
        send_image();
        // short tail after the last chunk
        put_pcm_file(16'd1, 16'd16, 32'd16000, 6);
        repeat (5) wave_image.push_back(8'($urandom));
        send_image();
        // eight byte tail forms an empty chunk
        put_pcm_file(16'd2, 16'd8, 32'd32000, 2);
        put_chunk($urandom, 0);
        send_image();
        // fmt shorter than sixteen bytes is skipped
        put_riff_head();
        put_chunk(TAG_FMT, 14);
        put_chunk(TAG_DATA, 2);
        send_image();
        // later fmt and data chunks win
        put_riff_head();
        put_fmt(16'd3, 16'd6, 32'd0, 16'd24, 2);
        put_chunk(TAG_DATA, 4);
        put_fmt(16'd1, 16'd2, 32'd48000, 16'd16, 0);
        put_chunk(TAG_DATA, 7);
        send_image();
        // empty data chunk replaces a good one
        put_pcm_file(16'd1, 16'd8, 32'd8000, 4);
        put_chunk(TAG_DATA, 0);
        send_image();
    endtask

    task automatic test_final_checks();
        put_riff_head();
        put_fmt(16'd3, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 2);
        send_image();
        put_riff_head();
        put_fmt(16'hFFFF, 16'd1, 32'd8000, 16'd8, 0);
        put_chunk(TAG_DATA, 2);
        send_image();
        put_riff_head();
        put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 0);
        send_image();
        put_pcm_file(16'd1, 16'd8, 32'd0, 2);
        send_image();
        put_pcm_file(16'd1, 16'd8, 32'h8000_0000, 2);
        send_image();
        put_pcm_file(16'd2, 16'd16, 32'hFFFF_FFFF, 2);
        send_image();
        put_pcm_file(16'd3, 16'd16, 32'd8000, 2);
        send_image();
        put_pcm_file(16'd1, 16'd24, 32'd8000, 2);
        send_image();
        put_pcm_file(16'd0, 16'd8, 32'd8000, 2);
        send_image();
        put_pcm_file(16'hFFFF, 16'hFFFF, 32'd8000, 2);
        send_image();
    endtask

    task automatic test_back_to_back();
        tx_quiet = 1'b1;
        repeat (4) begin
            put_pcm_file(16'($urandom_range(1, 2)), ($urandom_range(0, 1) == 0) ? 16'd8 : 16'd16,
                         $urandom_range(1, 96000), $urandom_range(1, 6));
            send_image();
        end
        rx_quiet = 1'b1;
        repeat (3) begin
            build_random_file();
            send_image();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_random_streams();
        int unsigned files;
        files = 0;
        wait_results_drained();
        while (bytes_accepted < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (files % 8 == 7) wait_results_drained();
            build_random_file();
            send_image();
            files++;
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        clear_wave_scan();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pcm_formats();
        test_header_faults();
        test_chunk_walk();
        test_final_checks();
        test_back_to_back();
        test_random_streams();
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
